>>> rtl/core/flr_pkg.sv
// ----------------------------------------------------------------------------
// flr_pkg: shared types and constants for the float literal recognizer
// Character codes, scan phase encoding and the result bundle passed from the
// scanner to the output stage.
// ----------------------------------------------------------------------------
package flr_pkg;

  localparam int CpW  = 21;
  localparam int LenW = 12;

  localparam logic [CpW-1:0] ChZero  = 21'h000030;
  localparam logic [CpW-1:0] ChNine  = 21'h000039;
  localparam logic [CpW-1:0] ChUnder = 21'h00005F;
  localparam logic [CpW-1:0] ChDot   = 21'h00002E;
  localparam logic [CpW-1:0] ChLowE  = 21'h000065;
  localparam logic [CpW-1:0] ChUpE   = 21'h000045;
  localparam logic [CpW-1:0] ChPlus  = 21'h00002B;
  localparam logic [CpW-1:0] ChMinus = 21'h00002D;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_INT_DIG  = 10'b00_0000_0010,
    PH_INT_US   = 10'b00_0000_0100,
    PH_DOT      = 10'b00_0000_1000,
    PH_FRAC_DIG = 10'b00_0001_0000,
    PH_FRAC_US  = 10'b00_0010_0000,
    PH_EXP_E    = 10'b00_0100_0000,
    PH_EXP_SIGN = 10'b00_1000_0000,
    PH_EXP_DIG  = 10'b01_0000_0000,
    PH_EXP_US   = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic            fire;
    logic            accepted;
    logic [LenW-1:0] length;
  } result_t;

endpackage

>>> rtl/core/flr_scanner.sv
// ----------------------------------------------------------------------------
// flr_scanner: literal scan state machine
// Holds the scan phase and the length counters; classifies one character per
// enabled cycle and reports a decision when the scan ends.
// ----------------------------------------------------------------------------
module flr_scanner
  import flr_pkg::*;
#(
  parameter logic [LenW-1:0] LenCap = 12'd4095
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           first_char,
  input  logic [CpW-1:0] char_code,
  output result_t        result
);

  phase_t          phase, phase_next;
  logic            seen_point, seen_point_next;
  logic [LenW-1:0] consumed, consumed_next;
  logic [LenW-1:0] marked, marked_next;

  logic is_digit, is_under, is_dot, is_e, is_sign;

  assign is_digit = (char_code >= ChZero) && (char_code <= ChNine);
  assign is_under = (char_code == ChUnder);
  assign is_dot   = (char_code == ChDot);
  assign is_e     = (char_code == ChLowE) || (char_code == ChUpE);
  assign is_sign  = (char_code == ChPlus) || (char_code == ChMinus);

  function automatic logic [LenW-1:0] sat_inc(input logic [LenW-1:0] v);
    return (v < LenCap) ? v + LenW'(1) : v;
  endfunction

  always_comb begin
    phase_next      = phase;
    seen_point_next = seen_point;
    consumed_next   = consumed;
    marked_next     = marked;
    result.fire     = 1'b0;
    result.accepted = 1'b0;

    if (first_char) begin
      seen_point_next = 1'b0;
      if (is_digit) begin
        consumed_next = sat_inc(LenW'(0));
        marked_next   = consumed_next;
        phase_next    = PH_INT_DIG;
      end else begin
        consumed_next = '0;
        marked_next   = '0;
        result.fire   = 1'b1;
      end
    end else begin
      case (phase)
        PH_INT_DIG: begin
          if (is_digit) begin
            consumed_next = sat_inc(consumed);
            marked_next   = consumed_next;
          end else if (is_under) begin
            consumed_next = sat_inc(consumed);
            phase_next    = PH_INT_US;
          end else if (is_dot) begin
            consumed_next = sat_inc(consumed);
            phase_next    = PH_DOT;
          end else if (is_e) begin
            consumed_next = sat_inc(consumed);
            phase_next    = PH_EXP_E;
          end else begin
            result.fire     = 1'b1;
            result.accepted = seen_point;
          end
        end
        PH_INT_US: begin
          if (is_digit) begin
            consumed_next = sat_inc(consumed);
            marked_next   = consumed_next;
            phase_next    = PH_INT_DIG;
          end else begin
            result.fire = 1'b1;
          end
        end
        PH_DOT: begin
          if (is_dot) begin
            result.fire = 1'b1;
          end else begin
            // the dot itself ends a valid literal from here on
            seen_point_next = 1'b1;
            marked_next     = consumed;
            if (is_digit) begin
              consumed_next = sat_inc(consumed);
              marked_next   = consumed_next;
              phase_next    = PH_FRAC_DIG;
            end else if (is_e) begin
              consumed_next = sat_inc(consumed);
              phase_next    = PH_EXP_E;
            end else begin
              result.fire     = 1'b1;
              result.accepted = 1'b1;
            end
          end
        end
        PH_FRAC_DIG: begin
          if (is_digit) begin
            consumed_next = sat_inc(consumed);
            marked_next   = consumed_next;
          end else if (is_under) begin
            consumed_next = sat_inc(consumed);
            phase_next    = PH_FRAC_US;
          end else if (is_e) begin
            consumed_next = sat_inc(consumed);
            phase_next    = PH_EXP_E;
          end else begin
            result.fire     = 1'b1;
            result.accepted = seen_point;
          end
        end
        PH_FRAC_US, PH_EXP_US: begin
          if (is_digit) begin
            consumed_next = sat_inc(consumed);
            marked_next   = consumed_next;
            phase_next    = (phase == PH_FRAC_US) ? PH_FRAC_DIG : PH_EXP_DIG;
          end else begin
            result.fire     = 1'b1;
            result.accepted = 1'b1;
          end
        end
        PH_EXP_E, PH_EXP_SIGN: begin
          if (is_sign && (phase == PH_EXP_E)) begin
            consumed_next = sat_inc(consumed);
            phase_next    = PH_EXP_SIGN;
          end else if (is_digit) begin
            consumed_next = sat_inc(consumed);
            marked_next   = consumed_next;
            phase_next    = PH_EXP_DIG;
          end else begin
            result.fire     = 1'b1;
            result.accepted = seen_point;
          end
        end
        PH_EXP_DIG: begin
          if (is_digit) begin
            consumed_next = sat_inc(consumed);
            marked_next   = consumed_next;
          end else if (is_under) begin
            consumed_next = sat_inc(consumed);
            phase_next    = PH_EXP_US;
          end else begin
            result.fire     = 1'b1;
            result.accepted = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (result.fire) begin
      phase_next = PH_IDLE;
    end
    result.length = result.accepted ? marked_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      seen_point <= 1'b0;
      consumed   <= '0;
      marked     <= '0;
    end else if (en) begin
      phase      <= phase_next;
      seen_point <= seen_point_next;
      consumed   <= consumed_next;
      marked     <= marked_next;
    end
  end

endmodule

>>> rtl/core/float_literal_recognizer.sv
// ----------------------------------------------------------------------------
// float_literal_recognizer: decimal float literal lexer, one character per item
// Each input item carries one code point; an item flagged as first starts a
// scan. Unless the output stalls, the block takes one item every clock cycle
// with no bubbles: the scan state machine decides in the same cycle the item
// is accepted, and the decision lands in a single output register, so the
// sustained rate is one item per cycle and a result appears in the cycle after
// its deciding character. The input stalls only while that output register
// holds an untaken result. A result is produced only on the deciding character
// (which is not counted in the length): tuser says accept (1) or reject (0),
// tdata carries the length up to the last valid end of the literal, saturating
// at the smaller of MAX_TOKEN_LENGTH and 4095, and zero on reject. Characters
// seen while no scan is running are dropped without a result.
// ----------------------------------------------------------------------------
module float_literal_recognizer
  import flr_pkg::*;
#(
  parameter int MAX_TOKEN_LENGTH = 4095
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [20:0] char_code, [23:21] zero
  input  logic        s_axis_tuser,   // [0] first_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] token_length, [15:12] zero
  output logic        m_axis_tuser    // [0] accepted
);

  // counters are fixed at the result field width, so the cap never exceeds it
  localparam int CapInt = (MAX_TOKEN_LENGTH < 4095) ? MAX_TOKEN_LENGTH : 4095;
  localparam logic [LenW-1:0] LenCap = LenW'(CapInt);

  logic    in_fire;
  result_t result;
  logic    out_acc;
  logic [LenW-1:0] out_len;

  // advance whenever the output register is empty or being emptied
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  flr_scanner #(
    .LenCap(LenCap)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .en        (in_fire),
    .first_char(s_axis_tuser),
    .char_code (s_axis_tdata[CpW-1:0]),
    .result    (result)
  );

  // output register: load on a decision, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire && result.fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && result.fire) begin
      out_acc <= result.accepted;
      out_len <= result.length;
    end
  end

  assign m_axis_tuser = out_acc;
  assign m_axis_tdata = {4'b0000, out_len};

endmodule

>>> rtl/core/flr_checker.sv
// ----------------------------------------------------------------------------
// flr_checker: port-level checks for the float literal recognizer
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module flr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // input never stalls while the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a new result only follows an accepted item
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without an input item");

  // reject carries zero length
  a_rej: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("reject with nonzero length");

  // accept covers at least one digit
  a_acc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[11:0] != 12'd0 &&
                                     m_axis_tdata[15:12] == 4'd0)
    else $error("accept with bad length");

endmodule

bind float_literal_recognizer flr_checker u_flr_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
